>>> design/hecd_pkg.sv
// Shared types, constants and the scancode table for the HID event decoder.
// No dependencies; every design file imports this package.
package hecd_pkg;

  // Cursor state width and the fixed widths of the clamp registers and ports.
  localparam int COORD_BITS = 11;
  localparam int LIM_BITS   = 11;
  localparam int SUM_BITS   = ((COORD_BITS > LIM_BITS) ? COORD_BITS : LIM_BITS) + 2;

  localparam logic [COORD_BITS-1:0] COORD_MAX  = {COORD_BITS{1'b1}};
  localparam logic [LIM_BITS-1:0]   MAX_X_INIT = LIM_BITS'(1024);
  localparam logic [LIM_BITS-1:0]   MAX_Y_INIT = LIM_BITS'(768);

  localparam logic [3:0] TYPE_KEY = 4'h1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_MAX_X = 1'b0,
    REG_MAX_Y = 1'b1
  } cfg_reg_t;

  // Key decode outcome for one word.
  typedef struct packed {
    logic       is_key;
    logic       char_valid;
    logic [6:0] char_code;
  } key_info_t;

  // US set-2 scancode to ASCII; indexes not in the table give 0.
  function automatic logic [6:0] key_rom(input logic [7:0] idx);
    logic [6:0] c;
    unique case (idx)
      8'd13:   c = 7'h09;
      8'd14:   c = 7'h60;
      8'd21:   c = 7'h71;
      8'd22:   c = 7'h31;
      8'd26:   c = 7'h7A;
      8'd27:   c = 7'h73;
      8'd28:   c = 7'h61;
      8'd29:   c = 7'h77;
      8'd30:   c = 7'h32;
      8'd33:   c = 7'h63;
      8'd34:   c = 7'h78;
      8'd35:   c = 7'h64;
      8'd36:   c = 7'h65;
      8'd37:   c = 7'h34;
      8'd38:   c = 7'h33;
      8'd41:   c = 7'h20;
      8'd42:   c = 7'h76;
      8'd43:   c = 7'h66;
      8'd44:   c = 7'h74;
      8'd45:   c = 7'h72;
      8'd46:   c = 7'h35;
      8'd49:   c = 7'h6E;
      8'd50:   c = 7'h62;
      8'd51:   c = 7'h68;
      8'd52:   c = 7'h67;
      8'd53:   c = 7'h79;
      8'd54:   c = 7'h36;
      8'd58:   c = 7'h6D;
      8'd59:   c = 7'h6A;
      8'd60:   c = 7'h75;
      8'd61:   c = 7'h37;
      8'd62:   c = 7'h38;
      8'd65:   c = 7'h2C;
      8'd66:   c = 7'h6B;
      8'd67:   c = 7'h69;
      8'd68:   c = 7'h6F;
      8'd69:   c = 7'h30;
      8'd70:   c = 7'h39;
      8'd73:   c = 7'h2E;
      8'd74:   c = 7'h2F;
      8'd75:   c = 7'h6C;
      8'd76:   c = 7'h3B;
      8'd77:   c = 7'h70;
      8'd78:   c = 7'h2D;
      8'd82:   c = 7'h27;
      8'd84:   c = 7'h5B;
      8'd85:   c = 7'h3D;
      8'd90:   c = 7'h0A;
      8'd91:   c = 7'h5D;
      8'd93:   c = 7'h5C;
      8'd102:  c = 7'h7F;
      8'd105:  c = 7'h31;
      8'd107:  c = 7'h34;
      8'd108:  c = 7'h37;
      8'd112:  c = 7'h30;
      8'd113:  c = 7'h2E;
      8'd114:  c = 7'h32;
      8'd115:  c = 7'h35;
      8'd116:  c = 7'h36;
      8'd117:  c = 7'h38;
      8'd118:  c = 7'h1B;
      8'd121:  c = 7'h2B;
      8'd122:  c = 7'h33;
      8'd123:  c = 7'h2D;
      8'd124:  c = 7'h2A;
      8'd125:  c = 7'h39;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

>>> design/hecd_key_decode.sv
// Key path of the HID event decoder: type check, flag check, scancode lookup.
// Depends on hecd_pkg.
module hecd_key_decode
  import hecd_pkg::*;
(
  input  logic [31:0] word,
  output key_info_t   info
);

  logic is_key;
  logic plain;

  assign is_key = (word[27:24] == TYPE_KEY);
  // Break flag and bit 23 both clear.
  assign plain  = !word[15] && !word[23];

  always_comb begin
    info.is_key     = is_key;
    info.char_valid = is_key && plain;
    info.char_code  = (is_key && plain) ? key_rom(word[7:0]) : 7'd0;
  end

endmodule

>>> design/hecd_cursor.sv
// Cursor state of the HID event decoder: clamp registers, position, move logic.
// Depends on hecd_pkg.
module hecd_cursor
  import hecd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  cfg_reg_t              cfg_sel,
  input  logic [LIM_BITS-1:0]   cfg_data,
  input  logic                  move,
  input  logic                  is_mouse,
  input  logic [7:0]            dx,
  input  logic [7:0]            dy,
  output logic [COORD_BITS-1:0] new_x,
  output logic [COORD_BITS-1:0] new_y
);

  logic [LIM_BITS-1:0]   max_x;
  logic [LIM_BITS-1:0]   max_y;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= MAX_X_INIT;
      max_y <= MAX_Y_INIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_sel)
        REG_MAX_X: max_x <= cfg_data;
        REG_MAX_Y: max_y <= cfg_data;
        default:   max_x <= max_x;
      endcase
    end
  end

  // Add a signed delta, then saturate to 0..min(lim, COORD_MAX).
  function automatic logic [COORD_BITS-1:0] clamp_move(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [SUM_BITS-1:0] delta,
    input logic [LIM_BITS-1:0] lim
  );
    logic signed [SUM_BITS-1:0] sum;
    logic [SUM_BITS-1:0]        hi;
    logic [COORD_BITS-1:0]      res;
    sum = $signed(SUM_BITS'(pos)) + delta;
    hi  = (SUM_BITS'(lim) > SUM_BITS'(COORD_MAX)) ? SUM_BITS'(COORD_MAX) : SUM_BITS'(lim);
    priority if (sum < 0) begin
      res = '0;
    end else if ($unsigned(sum) > hi) begin
      res = COORD_BITS'(hi);
    end else begin
      res = COORD_BITS'($unsigned(sum));
    end
    return res;
  endfunction

  logic signed [SUM_BITS-1:0] delta_x;
  logic signed [SUM_BITS-1:0] delta_y;

  assign delta_x = SUM_BITS'($signed(dx));
  assign delta_y = -SUM_BITS'($signed(dy));

  always_comb begin
    if (is_mouse) begin
      new_x = clamp_move(pos_x, delta_x, max_x);
      new_y = clamp_move(pos_y, delta_y, max_y);
    end else begin
      new_x = pos_x;
      new_y = pos_y;
    end
    pos_x_next = move ? new_x : pos_x;
    pos_y_next = move ? new_y : pos_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
    end
  end

endmodule

>>> design/hid_event_key_cursor_decoder_unit.sv
// Top level of the HID event decoder: input register, key and cursor paths,
// result register. Depends on hecd_pkg, hecd_key_decode and hecd_cursor.
// An accepted word moves from the input register to the result register; it
// waits in the input register while the old result is not taken, and a result
// is taken at an edge with out_ready high. One word per cycle while out_ready
// is high; hecd_cursor adds and clamps as the word leaves the input register.
// Reset (synchronous, rst high): both stages empty, cursor at 0,0,
// max_x 1024, max_y 768.
module hid_event_key_cursor_decoder_unit
  import hecd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration write port
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_index,
  input  logic [LIM_BITS-1:0] cfg_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         event_word,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_key_event,
  output logic                char_valid,
  output logic [6:0]          char_code,
  output logic [10:0]         cursor_x,
  output logic [10:0]         cursor_y,
  output logic [2:0]          buttons,
  output logic                cursor_updated
);

  // Input register: one word waiting for the decode stage.
  logic        word_valid;
  logic [31:0] word;
  // Advance the word into the result register when that register is free
  // or being drained this cycle.
  logic        advance;

  assign advance  = word_valid && (!out_valid || out_ready);
  // Take a new word whenever the input register is empty or moves on.
  assign in_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= event_word;
    end
  end

  // Key path: type nibble, flags, scancode lookup.
  key_info_t key_info;

  hecd_key_decode u_key (
    .word (word),
    .info (key_info)
  );

  // Cursor path: the position only moves when a mouse word advances.
  logic                  is_mouse;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_y;

  assign is_mouse = !key_info.is_key;

  hecd_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_sel   (cfg_reg_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .move      (advance && is_mouse),
    .is_mouse  (is_mouse),
    .dx        (word[7:0]),
    .dy        (word[15:8]),
    .new_x     (new_x),
    .new_y     (new_y)
  );

  // Result register: hold until taken, refill on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_key_event   <= key_info.is_key;
      char_valid     <= key_info.char_valid;
      char_code      <= key_info.char_code;
      cursor_x       <= 11'(new_x);
      cursor_y       <= 11'(new_y);
      // Buttons are reported with mouse words only.
      buttons        <= is_mouse ? word[18:16] : 3'd0;
      cursor_updated <= is_mouse;
    end
  end

  // A character is only ever reported for a key word.
  a_char_is_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> is_key_event)
    else $error("character reported for a non-key word");

  // Key words neither move the cursor nor carry buttons.
  a_key_no_mouse: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_key_event |-> !cursor_updated && (buttons == 3'd0))
    else $error("key word carries mouse fields");

  // With the result register empty, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

endmodule
